>>> design/rmdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmdr_pkg;

  // multiplier operand pair selects
  localparam logic [1:0] MUL_AN_BD = 2'd0;
  localparam logic [1:0] MUL_AD_BN = 2'd1;
  localparam logic [1:0] MUL_AN_BN = 2'd2;
  localparam logic [1:0] MUL_AD_BD = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init_num;
    logic       div_init_den;
    logic       div_step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic zero_den;
    logic zero_num;
    logic gcd_done;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

>>> design/rational_mul_div_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// Rational multiply / divide with reduction to lowest terms.
// Input: raise start with kind, a_num/a_den, b_num/b_den; the operands are
// taken at the edge where start is high and busy is low. busy stays high
// until the result is ready; start is ignored meanwhile.
// Output: done pulses for one cycle with res_num, res_den, inputs_equal
// and invalid valid in that cycle; the fields then hold until the next result.
// Sequence, from the accepting edge to the edge that takes the result: four
// products, one at a time through one shared IN_WIDTH x IN_WIDTH
// multiplier, a check state, a binary GCD of shift/subtract steps on the
// magnitudes, then two restoring divisions of the magnitudes by the GCD
// (MW = 2*IN_WIDTH-1), a handoff state between them and a result state.
// Zero numerator or zero denominator skip the GCD and divisions. One item
// at a time; the GCD loop and the serial divider take the longest.
// Reset (synchronous, rst high) returns the controller to idle and clears
// done; the result fields are not reset. The receiver cannot stall: each
// result is taken in its done cycle, and a new start is accepted then.
module rational_mul_div_reduce #(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic signed [IN_WIDTH-1:0] a_num,
  input  logic signed [IN_WIDTH-1:0] a_den,
  input  logic signed [IN_WIDTH-1:0] b_num,
  input  logic signed [IN_WIDTH-1:0] b_den,
  output logic                       done,
  output logic signed [31:0]         res_num,
  output logic [30:0]                res_den,
  output logic                       inputs_equal,
  output logic                       invalid
);

  rmdr_pkg::cmd_t  cmd;
  rmdr_pkg::stat_t stat;

  rmdr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rmdr_dp #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .kind         (kind),
    .a_num        (a_num),
    .a_den        (a_den),
    .b_num        (b_num),
    .b_den        (b_den),
    .stat         (stat),
    .res_num      (res_num),
    .res_den      (res_den),
    .inputs_equal (inputs_equal),
    .invalid      (invalid)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a preceding busy period");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && invalid |-> res_num == 32'sd0 && res_den == 31'd0)
    else $error("invalid result carries nonzero terms");

  a_valid_den: assert property (@(posedge clk) disable iff (rst)
    done && !invalid |-> res_den != 31'd0)
    else $error("valid result with zero denominator");

  a_zero_num: assert property (@(posedge clk) disable iff (rst)
    done && !invalid && res_num == 32'sd0 |-> res_den == 31'd1)
    else $error("zero numerator not reduced to 0/1");

endmodule
`default_nettype wire

>>> design/rmdr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rmdr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rmdr_pkg::stat_t stat,
  output rmdr_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_GCD   = 3'd3;
  localparam logic [2:0] S_DIVN  = 3'd4;
  localparam logic [2:0] S_SWAP  = 3'd5;
  localparam logic [2:0] S_DIVD  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] mcnt, mcnt_next;

  always_comb begin
    state_next = state;
    mcnt_next  = mcnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          mcnt_next  = rmdr_pkg::MUL_AN_BD;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mcnt;
        mcnt_next   = mcnt + 2'd1;
        if (mcnt == rmdr_pkg::MUL_AD_BD) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.zero_den || stat.zero_num) begin
          state_next = S_FIN;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_init_num = 1'b1;
          state_next       = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_SWAP;
      end
      S_SWAP: begin
        cmd.div_init_den = 1'b1;
        state_next       = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mcnt  <= rmdr_pkg::MUL_AN_BD;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      mcnt  <= mcnt_next;
      done  <= (state == S_FIN);
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

>>> design/rmdr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module rmdr_dp #(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  rmdr_pkg::cmd_t             cmd,
  input  logic                       kind,
  input  logic signed [IN_WIDTH-1:0] a_num,
  input  logic signed [IN_WIDTH-1:0] a_den,
  input  logic signed [IN_WIDTH-1:0] b_num,
  input  logic signed [IN_WIDTH-1:0] b_den,
  output rmdr_pkg::stat_t            stat,
  output logic signed [31:0]         res_num,
  output logic [30:0]                res_den,
  output logic                       inputs_equal,
  output logic                       invalid
);

  localparam int PW = 2 * IN_WIDTH;
  localparam int MW = PW - 1;
  localparam int CW = $clog2(MW);
  localparam int XW = (MW + 1 > 32) ? MW + 1 : 32;

  logic                       kind_r;
  logic signed [IN_WIDTH-1:0] an, ad, bn, bd;
  logic signed [IN_WIDTH-1:0] op_a, op_b;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       p [4];
  logic signed [PW-1:0]       num, den, num_neg, den_neg;
  logic [MW-1:0]              mn, md;
  logic                       neg;

  logic [MW-1:0] u, v, g, gval;
  logic [CW-1:0] k;
  logic [MW-1:0] dq, rem, qn;
  logic [CW-1:0] dcnt;
  logic [MW:0]   trial, trial_sub;
  logic          qbit;
  logic [XW-1:0] qn_x, qd_x, sn_x;

  always_comb begin
    case (cmd.mul_sel)
      rmdr_pkg::MUL_AN_BD: begin op_a = an; op_b = bd; end
      rmdr_pkg::MUL_AD_BN: begin op_a = ad; op_b = bn; end
      rmdr_pkg::MUL_AN_BN: begin op_a = an; op_b = bn; end
      rmdr_pkg::MUL_AD_BD: begin op_a = ad; op_b = bd; end
      default:             begin op_a = an; op_b = bn; end
    endcase
  end

  assign prod = PW'(op_a) * PW'(op_b);

  // divide uses an*bd over ad*bn, multiply an*bn over ad*bd
  assign num     = kind_r ? p[rmdr_pkg::MUL_AN_BD] : p[rmdr_pkg::MUL_AN_BN];
  assign den     = kind_r ? p[rmdr_pkg::MUL_AD_BN] : p[rmdr_pkg::MUL_AD_BD];
  assign num_neg = -num;
  assign den_neg = -den;
  assign mn      = num[PW-1] ? num_neg[MW-1:0] : num[MW-1:0];
  assign md      = den[PW-1] ? den_neg[MW-1:0] : den[MW-1:0];
  assign neg     = num[PW-1] ^ den[PW-1];

  assign gval = (u | v) << k;

  assign trial     = {rem, dq[MW-1]};
  assign trial_sub = trial - {1'b0, g};
  assign qbit      = !trial_sub[MW];

  assign stat.zero_den = (den == '0);
  assign stat.zero_num = (num == '0);
  assign stat.gcd_done = (u == '0) || (v == '0);
  assign stat.div_last = (dcnt == CW'(MW - 1));

  assign qn_x = XW'(qn);
  assign qd_x = XW'(dq);
  assign sn_x = neg ? -qn_x : qn_x;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      an     <= a_num;
      ad     <= a_den;
      bn     <= b_num;
      bd     <= b_den;
    end
    if (cmd.mul_en) p[cmd.mul_sel] <= prod;

    // binary GCD: strip common twos into k, halve a lone even operand, subtract odd from odd
    if (cmd.gcd_init) begin
      u <= mn;
      v <= md;
      k <= '0;
    end else if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + CW'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end

    // restoring divider, one quotient bit per cycle
    if (cmd.div_init_num) begin
      g    <= gval;
      dq   <= mn;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_init_den) begin
      qn   <= dq;
      dq   <= md;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= qbit ? trial_sub[MW-1:0] : trial[MW-1:0];
      dq   <= {dq[MW-2:0], qbit};
      dcnt <= dcnt + CW'(1);
    end

    if (cmd.finish) begin
      inputs_equal <= (p[rmdr_pkg::MUL_AN_BD] == p[rmdr_pkg::MUL_AD_BN]);
      invalid      <= stat.zero_den;
      if (stat.zero_den) begin
        res_num <= '0;
        res_den <= '0;
      end else if (stat.zero_num) begin
        res_num <= '0;
        res_den <= 31'd1;
      end else begin
        res_num <= sn_x[31:0];
        res_den <= qd_x[30:0];
      end
    end
  end

endmodule
`default_nettype wire
